/* design/sam_pkg.sv */
package sam_pkg;

  localparam int unsigned DefaultDepth      = 1024;
  localparam int unsigned DefaultKeyWidth   = 32;
  localparam int unsigned DefaultValueWidth = 32;

  localparam int unsigned CmdWidth    = 1;
  localparam int unsigned KeyPortW    = 32;
  localparam int unsigned ValuePortW  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned TotalWidth  = 11;

  localparam logic [CmdWidth-1:0] CmdAdd    = 1'b0;
  localparam logic [CmdWidth-1:0] CmdLookup = 1'b1;

  localparam logic [StatusWidth-1:0] StOk   = 2'd0;
  localparam logic [StatusWidth-1:0] StDup  = 2'd1;
  localparam logic [StatusWidth-1:0] StFull = 2'd2;
  localparam logic [StatusWidth-1:0] StMiss = 2'd3;

  // Transaction as it travels from the front part to the back part.
  typedef struct packed {
    logic [CmdWidth-1:0]   cmd;
    logic [KeyPortW-1:0]   key;
    logic [ValuePortW-1:0] value;
  } txn_t;

endpackage

/* design/sorted_array_map.sv */
// Sorted key/value table with binary search.
// A command transaction (cmd_i, key_i, value_i) is taken at a rising edge
// at which start is high and busy is low. cmd 0 adds a pair, cmd 1 looks a
// key up. Each transaction yields exactly one result, shown for one cycle
// while done_o is high: status_o, found_o, read_value_o and entry_total_o.
// The receiver cannot stall; a result must be taken in its cycle.
// A front part registers the command into a one-entry queue; a back part
// runs a binary search over the key memory; the memory read is registered,
// so each probe presents the address in SProbe and compares the registered
// read data in SComp. An add then shifts the higher entries up one slot per
// cycle and writes the new pair. busy stays high from acceptance until the
// result has gone. Reset clears the entry count and the control state;
// the memories are not cleared, as only entries below the count are read.
module sorted_array_map #(
  parameter int unsigned DEPTH       = sam_pkg::DefaultDepth,
  parameter int unsigned KEY_WIDTH   = sam_pkg::DefaultKeyWidth,
  parameter int unsigned VALUE_WIDTH = sam_pkg::DefaultValueWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sam_pkg::CmdWidth-1:0]      cmd_i,
  input  logic [sam_pkg::KeyPortW-1:0]      key_i,
  input  logic [sam_pkg::ValuePortW-1:0]    value_i,
  output logic                              done_o,
  output logic [sam_pkg::StatusWidth-1:0]   status_o,
  output logic                              found_o,
  output logic [sam_pkg::ValuePortW-1:0]    read_value_o,
  output logic [sam_pkg::TotalWidth-1:0]    entry_total_o
);

  logic          q_valid, q_pop, idle;
  sam_pkg::txn_t q_txn;

  sam_front u_front (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .key_i, .value_i,
    .q_valid_o(q_valid), .q_txn_o(q_txn), .q_pop_i(q_pop)
  );

  sam_back #(.Depth(DEPTH), .KeyWidth(KEY_WIDTH), .ValueWidth(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_txn_i(q_txn), .q_pop_o(q_pop),
    .idle_o(idle), .done_o, .status_o, .found_o, .read_value_o, .entry_total_o
  );

  // One transaction in flight at a time; the result cycle also counts busy.
  assign busy = !idle || done_o;

endmodule

/* design/sam_ram.sv */
module sam_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/sam_front.sv */
module sam_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic                             busy,
  input  logic [sam_pkg::CmdWidth-1:0]     cmd_i,
  input  logic [sam_pkg::KeyPortW-1:0]     key_i,
  input  logic [sam_pkg::ValuePortW-1:0]   value_i,
  output logic                             q_valid_o,
  output sam_pkg::txn_t                    q_txn_o,
  input  logic                             q_pop_i
);

  // Single-entry queue: the port's busy keeps it from overflowing.
  logic          valid_q, valid_d;
  sam_pkg::txn_t txn_q;

  always_comb begin
    valid_d = valid_q;
    if (q_pop_i) begin
      valid_d = 1'b0;
    end
    if (start && !busy) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      txn_q.cmd   <= cmd_i;
      txn_q.key   <= key_i;
      txn_q.value <= value_i;
    end
  end

  assign q_valid_o = valid_q;
  assign q_txn_o   = txn_q;

endmodule

/* design/sam_back.sv */
module sam_back #(
  parameter int unsigned Depth      = sam_pkg::DefaultDepth,
  parameter int unsigned KeyWidth   = sam_pkg::DefaultKeyWidth,
  parameter int unsigned ValueWidth = sam_pkg::DefaultValueWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  sam_pkg::txn_t                      q_txn_i,
  output logic                               q_pop_o,
  output logic                               idle_o,
  output logic                               done_o,
  output logic [sam_pkg::StatusWidth-1:0]    status_o,
  output logic                               found_o,
  output logic [sam_pkg::ValuePortW-1:0]     read_value_o,
  output logic [sam_pkg::TotalWidth-1:0]     entry_total_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SProbe = 3'd1;
  localparam logic [2:0] SComp  = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SMove  = 3'd4;
  localparam logic [2:0] SPut   = 3'd5;
  localparam logic [2:0] SLast  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d, lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [CW-1:0] mid;
  logic [sam_pkg::CmdWidth-1:0] cmd_q;
  logic [KeyWidth-1:0]   key_q;
  logic [ValueWidth-1:0] val_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [KeyWidth-1:0]   kw, kr;
  logic [ValueWidth-1:0] vw, vr;
  logic done_d, found_d;
  logic [sam_pkg::StatusWidth-1:0] status_d;
  logic [ValueWidth-1:0] rv_d;
  logic done_q, found_q;
  logic [sam_pkg::StatusWidth-1:0] status_q;
  logic [ValueWidth-1:0] rv_q;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  sam_ram #(.Width(KeyWidth), .Depth(Depth)) u_keys (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(kw), .raddr_i(raddr), .rdata_o(kr)
  );
  sam_ram #(.Width(ValueWidth), .Depth(Depth)) u_vals (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(vw), .raddr_i(raddr), .rdata_o(vr)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ptr_d    = ptr_q;
    q_pop_o  = 1'b0;
    raddr    = mid[AW-1:0];
    waddr    = ptr_q[AW-1:0];
    we       = 1'b0;
    kw       = kr;
    vw       = vr;
    done_d   = 1'b0;
    found_d  = 1'b0;
    status_d = sam_pkg::StOk;
    rv_d     = '0;
    case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          lo_d    = '0;
          hi_d    = count_q;
          state_d = SProbe;
        end
      end
      SProbe: begin
        if (lo_q < hi_q) begin
          state_d = SComp;
        end else if (cmd_q == sam_pkg::CmdLookup) begin
          done_d   = 1'b1;
          status_d = sam_pkg::StMiss;
          state_d  = SIdle;
        end else if (count_q >= CW'(Depth)) begin
          done_d   = 1'b1;
          status_d = sam_pkg::StFull;
          state_d  = SIdle;
        end else if (count_q == lo_q) begin
          state_d = SPut;
        end else begin
          ptr_d   = count_q;
          raddr   = AW'(count_q - 1'b1);
          state_d = SMove;
        end
      end
      SComp: begin
        // Read data for mid is now registered.
        if (kr == key_q) begin
          done_d  = 1'b1;
          state_d = SIdle;
          if (cmd_q == sam_pkg::CmdLookup) begin
            status_d = sam_pkg::StOk;
            state_d  = SRead;
            done_d   = 1'b0;
          end else begin
            status_d = sam_pkg::StDup;
          end
        end else begin
          if (kr < key_q) begin
            lo_d = mid + 1'b1;
          end else begin
            hi_d = mid;
          end
          state_d = SProbe;
        end
      end
      SRead: begin
        done_d   = 1'b1;
        found_d  = 1'b1;
        rv_d     = vr;
        state_d  = SIdle;
      end
      SMove: begin
        // Entry ptr-1 is on the read port; copy it to ptr.
        we    = 1'b1;
        ptr_d = ptr_q - 1'b1;
        raddr = AW'(ptr_q - 2'd2);
        if (ptr_d == lo_q) begin
          state_d = SPut;
        end
      end
      SPut: begin
        we       = 1'b1;
        waddr    = lo_q[AW-1:0];
        kw       = key_q;
        vw       = val_q;
        count_d  = count_q + 1'b1;
        done_d   = 1'b1;
        state_d  = SLast;
      end
      SLast: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    ptr_q    <= ptr_d;
    found_q  <= found_d;
    status_q <= status_d;
    rv_q     <= rv_d;
    if (q_pop_o) begin
      cmd_q <= q_txn_i.cmd;
      key_q <= KeyWidth'(q_txn_i.key);
      val_q <= ValueWidth'(q_txn_i.value);
    end
  end

  assign idle_o        = (state_q == SIdle) && !q_valid_i;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign read_value_o  = sam_pkg::ValuePortW'(rv_q);
  assign entry_total_o = sam_pkg::TotalWidth'(count_q);

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth)) else $error("entry count beyond depth");
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
    else $error("entry count moved by other than one");
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && found_q |-> status_q == sam_pkg::StOk) else $error("found without ok");
  a_search_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SComp |-> lo_q < hi_q && hi_q <= count_q) else $error("bad search window");
`endif

endmodule
